@@ rtl/core/blfb_pkg.sv @@
package blfb_pkg;

  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_PIXEL = 3'd1;
  localparam logic [2:0] ACT_BYTE  = 3'd2;
  localparam logic [2:0] ACT_LINE  = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic       color;
    logic [7:0] page_index;
    logic [7:0] column_index;
    logic [7:0] byte_value;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] done_action;
  } rsp_t;

  typedef struct packed {
    logic [7:0] x1;
    logic [7:0] y1;
    logic [7:0] x2;
    logic [7:0] y2;
  } line_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic       last;
  } point_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OP,
    ST_LINE_RD,
    ST_LINE_WR,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    WM_VERT,
    WM_HORZ,
    WM_XMAJ,
    WM_YMAJ
  } walk_mode_e;

  function automatic logic [7:0] paint(input logic [7:0] data, input logic [2:0] bit_sel,
                                       input logic color);
    logic [7:0] mask;
    mask = 8'd1 << bit_sel;
    return color ? (data & ~mask) : (data | mask);
  endfunction

endpackage

@@ rtl/core/blfb_ram.sv @@
module blfb_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/core/blfb_walk.sv @@
module blfb_walk (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           step_i,
  input  blfb_pkg::line_t line_i,
  output blfb_pkg::point_t pt_o
);

  blfb_pkg::walk_mode_e mode_q, mode_d;
  logic [7:0] walk_x_q, walk_x_d;
  logic [7:0] walk_y_q, walk_y_d;
  logic [7:0] end_x_q, end_x_d;
  logic [7:0] end_y_q, end_y_d;
  logic [7:0] dx_q, dx_d;
  logic [7:0] dy_q, dy_d;
  logic       neg_x_q, neg_x_d;
  logic       neg_y_q, neg_y_d;
  logic signed [9:0] walk_error_q, walk_error_d;

  logic [7:0] major, minor;
  logic [7:0] next_x, next_y;
  logic signed [9:0]  err_t;
  logic signed [10:0] err2;
  logic               hit;

  assign major  = (mode_q == blfb_pkg::WM_XMAJ) ? dx_q : dy_q;
  assign minor  = (mode_q == blfb_pkg::WM_XMAJ) ? dy_q : dx_q;
  assign err_t  = walk_error_q + $signed({2'b00, minor});
  assign err2   = {err_t, 1'b0};
  assign hit    = err2 >= $signed({3'b000, major});
  assign next_x = neg_x_q ? walk_x_q - 8'd1 : walk_x_q + 8'd1;
  assign next_y = neg_y_q ? walk_y_q - 8'd1 : walk_y_q + 8'd1;

  always_comb begin
    mode_d       = mode_q;
    walk_x_d     = walk_x_q;
    walk_y_d     = walk_y_q;
    end_x_d      = end_x_q;
    end_y_d      = end_y_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    neg_x_d      = neg_x_q;
    neg_y_d      = neg_y_q;
    walk_error_d = walk_error_q;
    if (start_i) begin
      walk_error_d = '0;
      neg_x_d      = line_i.x2 < line_i.x1;
      neg_y_d      = line_i.y2 < line_i.y1;
      dx_d         = neg_x_d ? line_i.x1 - line_i.x2 : line_i.x2 - line_i.x1;
      dy_d         = neg_y_d ? line_i.y1 - line_i.y2 : line_i.y2 - line_i.y1;
      walk_x_d     = line_i.x1;
      walk_y_d     = line_i.y1;
      end_x_d      = line_i.x2;
      end_y_d      = line_i.y2;
      if (line_i.x1 == line_i.x2) begin
        mode_d   = blfb_pkg::WM_VERT;
        walk_y_d = neg_y_d ? line_i.y2 : line_i.y1;
        end_y_d  = neg_y_d ? line_i.y1 : line_i.y2;
      end else if (line_i.y1 == line_i.y2) begin
        mode_d   = blfb_pkg::WM_HORZ;
        walk_x_d = neg_x_d ? line_i.x2 : line_i.x1;
        end_x_d  = neg_x_d ? line_i.x1 : line_i.x2;
      end else begin
        mode_d = (dx_d > dy_d) ? blfb_pkg::WM_XMAJ : blfb_pkg::WM_YMAJ;
      end
    end else if (step_i) begin
      unique case (mode_q)
        blfb_pkg::WM_VERT: walk_y_d = walk_y_q + 8'd1;
        blfb_pkg::WM_HORZ: walk_x_d = walk_x_q + 8'd1;
        blfb_pkg::WM_XMAJ: begin
          walk_x_d     = next_x;
          walk_y_d     = hit ? next_y : walk_y_q;
          walk_error_d = hit ? err_t - $signed({2'b00, major}) : err_t;
        end
        blfb_pkg::WM_YMAJ: begin
          walk_y_d     = next_y;
          walk_x_d     = hit ? next_x : walk_x_q;
          walk_error_d = hit ? err_t - $signed({2'b00, major}) : err_t;
        end
      endcase
    end
  end

  always_comb begin
    pt_o.x = walk_x_q;
    pt_o.y = walk_y_q;
    unique case (mode_q)
      blfb_pkg::WM_VERT: pt_o.last = walk_y_q == end_y_q;
      blfb_pkg::WM_HORZ: pt_o.last = walk_x_q == end_x_q;
      blfb_pkg::WM_XMAJ: pt_o.last = next_x == end_x_q;
      blfb_pkg::WM_YMAJ: pt_o.last = next_y == end_y_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= blfb_pkg::WM_VERT;
      walk_x_q     <= '0;
      walk_y_q     <= '0;
      end_x_q      <= '0;
      end_y_q      <= '0;
      dx_q         <= '0;
      dy_q         <= '0;
      neg_x_q      <= 1'b0;
      neg_y_q      <= 1'b0;
      walk_error_q <= '0;
    end else begin
      mode_q       <= mode_d;
      walk_x_q     <= walk_x_d;
      walk_y_q     <= walk_y_d;
      end_x_q      <= end_x_d;
      end_y_q      <= end_y_d;
      dx_q         <= dx_d;
      dy_q         <= dy_d;
      neg_x_q      <= neg_x_d;
      neg_y_q      <= neg_y_d;
      walk_error_q <= walk_error_d;
    end
  end

endmodule

@@ rtl/core/bresenham_line_framebuffer_top.sv @@
// Monochrome frame buffer of PAGE_COUNT pages by COLUMN_COUNT columns held in one
// synchronous memory, with a line drawer. Pixel set and line requests are
// read-modify-write sequences on that memory's single write port and single read
// port; a byte write replaces the whole byte and a clear writes zeros. In a line
// each visited point is read and then written back; a clear sweeps one entry per
// cycle. After reset the same sweep over all PAGE_COUNT*COLUMN_COUNT entries runs
// before the first request is taken. Each request gives one response through an
// output register; a new request is taken while the previous response still waits
// there.
module bresenham_line_framebuffer_top #(
  parameter int PAGE_COUNT   = 8,
  parameter int COLUMN_COUNT = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  blfb_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output blfb_pkg::rsp_t  out_rsp_o
);

  localparam int DEPTH     = PAGE_COUNT * COLUMN_COUNT;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int ROW_COUNT = PAGE_COUNT * 8;

  function automatic logic [ADDR_W-1:0] frame_addr(input logic [7:0] page,
                                                   input logic [7:0] col);
    logic [15:0] lin;
    lin = 16'(page) * 16'(COLUMN_COUNT) + 16'(col);
    return lin[ADDR_W-1:0];
  endfunction

  function automatic logic pixel_inside(input logic [7:0] x, input logic [7:0] y);
    return (9'(x) < 9'(COLUMN_COUNT)) && (9'(y) < 9'(ROW_COUNT));
  endfunction

  function automatic logic byte_inside(input logic [7:0] page, input logic [7:0] col);
    return (9'(page) < 9'(PAGE_COUNT)) && (9'(col) < 9'(COLUMN_COUNT));
  endfunction

  blfb_pkg::state_e state_q, state_d;
  blfb_pkg::req_t   req_q, req_d;
  blfb_pkg::rsp_t   out_q, out_d, hold_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic             clr_resp_q, clr_resp_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic             inside_q, inside_d;
  logic [2:0]       bit_q, bit_d;

  logic              accept, out_free, clr_last, fin, out_load, hold_load, loc_load;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              walk_start, walk_step;
  blfb_pkg::line_t   line;
  blfb_pkg::point_t  pt;

  assign in_stall_o = state_q != blfb_pkg::ST_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign clr_last   = clr_cnt_q == ADDR_W'(DEPTH - 1);
  assign line       = '{x1: in_req_i.x_start, y1: in_req_i.y_start,
                        x2: in_req_i.x_end,   y2: in_req_i.y_end};

  blfb_ram #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  blfb_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(walk_start),
    .step_i (walk_step),
    .line_i (line),
    .pt_o   (pt)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      blfb_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_req_i.action == blfb_pkg::ACT_CLEAR) begin
            state_d = blfb_pkg::ST_CLEAR;
          end else if (in_req_i.action == blfb_pkg::ACT_LINE) begin
            state_d = blfb_pkg::ST_LINE_RD;
          end else begin
            state_d = blfb_pkg::ST_OP;
          end
        end
      end
      blfb_pkg::ST_OP: begin
        state_d = out_free ? blfb_pkg::ST_IDLE : blfb_pkg::ST_DONE;
      end
      blfb_pkg::ST_LINE_RD: begin
        state_d = blfb_pkg::ST_LINE_WR;
      end
      blfb_pkg::ST_LINE_WR: begin
        if (pt.last) begin
          state_d = out_free ? blfb_pkg::ST_IDLE : blfb_pkg::ST_DONE;
        end else begin
          state_d = blfb_pkg::ST_LINE_RD;
        end
      end
      blfb_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = (clr_resp_q && !out_free) ? blfb_pkg::ST_DONE : blfb_pkg::ST_IDLE;
        end
      end
      blfb_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = blfb_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = blfb_pkg::paint(mem_rdata, bit_q, req_q.color);
    mem_re     = 1'b0;
    mem_raddr  = frame_addr({3'b000, pt.y[7:3]}, pt.x);
    walk_start = 1'b0;
    walk_step  = 1'b0;
    fin        = 1'b0;
    loc_load   = 1'b0;
    addr_d     = mem_raddr;
    inside_d   = pixel_inside(pt.x, pt.y);
    bit_d      = pt.y[2:0];
    req_d      = req_q;
    clr_cnt_d  = clr_cnt_q;
    clr_resp_d = clr_resp_q;
    res_d.done_action = req_q.action;
    res_d.read_data   = 8'd0;
    unique case (state_q)
      blfb_pkg::ST_IDLE: begin
        if (in_req_i.action == blfb_pkg::ACT_BYTE || in_req_i.action == blfb_pkg::ACT_READ) begin
          mem_raddr = frame_addr(in_req_i.page_index, in_req_i.column_index);
          inside_d  = byte_inside(in_req_i.page_index, in_req_i.column_index);
        end else begin
          mem_raddr = frame_addr({3'b000, in_req_i.y_start[7:3]}, in_req_i.x_start);
          inside_d  = pixel_inside(in_req_i.x_start, in_req_i.y_start);
        end
        addr_d = mem_raddr;
        bit_d  = in_req_i.y_start[2:0];
        if (accept) begin
          mem_re     = 1'b1;
          loc_load   = 1'b1;
          req_d      = in_req_i;
          walk_start = in_req_i.action == blfb_pkg::ACT_LINE;
          clr_resp_d = in_req_i.action == blfb_pkg::ACT_CLEAR;
        end
      end
      blfb_pkg::ST_OP: begin
        fin = 1'b1;
        unique case (req_q.action)
          blfb_pkg::ACT_PIXEL: mem_we = inside_q;
          blfb_pkg::ACT_BYTE: begin
            mem_we    = inside_q;
            mem_wdata = req_q.color ? ~req_q.byte_value : req_q.byte_value;
          end
          blfb_pkg::ACT_READ: res_d.read_data = inside_q ? mem_rdata : 8'd0;
          default: ;
        endcase
      end
      blfb_pkg::ST_LINE_RD: begin
        mem_re   = 1'b1;
        loc_load = 1'b1;
      end
      blfb_pkg::ST_LINE_WR: begin
        mem_we    = inside_q;
        walk_step = !pt.last;
        fin       = pt.last;
      end
      blfb_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = 8'd0;
        clr_cnt_d = clr_last ? '0 : clr_cnt_q + ADDR_W'(1);
        fin       = clr_last && clr_resp_q;
      end
      blfb_pkg::ST_DONE: ;
    endcase
  end

  assign out_load    = (fin || state_q == blfb_pkg::ST_DONE) && out_free;
  assign hold_load   = fin && !out_free;
  assign out_d       = (state_q == blfb_pkg::ST_DONE) ? hold_q : res_d;
  assign out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blfb_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
      clr_resp_q  <= 1'b0;
      clr_cnt_q   <= '0;
      inside_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clr_resp_q  <= clr_resp_d;
      clr_cnt_q   <= clr_cnt_d;
      if (loc_load) begin
        inside_q <= inside_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (loc_load) begin
      addr_q <= addr_d;
      bit_q  <= bit_d;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    if (hold_load) begin
      hold_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_rmw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q == blfb_pkg::ST_LINE_WR ||
                (state_q == blfb_pkg::ST_OP && req_q.action == blfb_pkg::ACT_PIXEL)))
    |-> (mem_waddr == $past(mem_raddr)))
    else $error("write-back address differs from the address that was read");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !out_load)
    else $error("pending response overwritten");

  a_read_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.done_action != blfb_pkg::ACT_READ) |-> (out_d.read_data == 8'd0))
    else $error("nonzero read data on a request that is not a read");

endmodule
